// ===== design/crcfr_pkg.sv =====
// crcfr_pkg: shared types, constants and the crc8 step function for the
// crc8 frame receiver; no dependencies
package crcfr_pkg;

  localparam int unsigned LEN_W = 7;

  localparam logic [7:0] CRC_POLY    = 8'h16;
  localparam logic [7:0] START_BYTE  = 8'hFA;
  localparam logic [7:0] DATA_MARK   = 8'hFB;
  localparam logic [7:0] STOP_BYTE   = 8'hFE;

  localparam logic [1:0] ADDR_MAX_ACCEPT = 2'd0;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_HDR_CRC,
    PH_DATA_MK,
    PH_PAYLOAD,
    PH_PKT_CRC,
    PH_STOP
  } phase_e;

  typedef enum logic {
    DR_IDLE,
    DR_SHOW
  } drain_e;

  // one verified frame waiting to be drained
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             empty;
  } frame_cmd_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/crc8_frame_receiver_unit.sv =====
// crc8_frame_receiver_unit: top level of the crc8 frame receiver
// instantiates crcfr_front, crcfr_queue and crcfr_back; uses crcfr_pkg
//
// usage
//   rx channel: one link byte per request (rx_valid_i, rx_byte_i, rx_stall_o)
//   out channel: one payload byte per request of a verified frame, with its
//     frame_len, is_empty and last flags (out_valid_o, out_stall_i)
//   apb port: register 0 at address 0 is max_accept_len (reset 64)
// throughput: one link byte per cycle while hunting and checking, when rx_stall_o
//   is low; a frame request goes into a two-entry queue after its stop byte
// output: with the drain side idle, a stop byte's frame passes the queue entry
//   and read register, then shows one byte per cycle while out_stall_i is low
// stalls: rx_stall_o rises while a payload byte would overwrite the single
//   payload store that the drain side still reads, or when the queue is full
//   at the stop byte; out_stall_i holds the current result steady
// reset: hunting for a start byte, queue empty, no output valid; the
//   payload store needs no clearing
module crc8_frame_receiver_unit import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             rx_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic [LEN_W-1:0] frame_len_o,
  output logic             is_empty_o,
  output logic             last_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [LEN_W-1:0] max_accept_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             push, pop;
  frame_cmd_t       push_cmd, head;
  logic             q_empty, q_full;
  logic             back_busy;
  logic             store_busy;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_ACCEPT) ? {{(32-LEN_W){1'b0}}, max_accept_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accept_q <= LEN_W'(64);
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_ACCEPT)) begin
      max_accept_q <= pwdata[LEN_W-1:0];
    end
  end

  assign store_busy = back_busy || !q_empty;

  crcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_byte_i       (rx_byte_i),
    .rx_stall_o      (rx_stall_o),
    .max_accept_len_i(max_accept_q),
    .store_busy_i    (store_busy),
    .q_full_i        (q_full),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .push_o          (push),
    .push_cmd_o      (push_cmd)
  );

  crcfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  crcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .busy_o     (back_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_byte_o(data_byte_o),
    .frame_len_o(frame_len_o),
    .is_empty_o (is_empty_o),
    .last_o     (last_o)
  );

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> last_o && (frame_len_o == '0))
    else $error("empty marker without last or with nonzero length");

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> (frame_len_o != '0) &&
      (frame_len_o <= LEN_W'(MAX_PAYLOAD)))
    else $error("payload result with bad frame length");

  a_no_write_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !back_busy && q_empty)
    else $error("payload store written while a frame is pending");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("frame queue overflow");

endmodule

// ===== design/crcfr_front.sv =====
// crcfr_front: frame hunting and checking state machine, writes payload bytes
// into the back part's store and pushes verified frames; uses crcfr_pkg
module crcfr_front import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64,
  parameter int unsigned AW          = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             rx_stall_o,
  input  logic [LEN_W-1:0] max_accept_len_i,
  input  logic             store_busy_i,
  input  logic             q_full_i,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic             push_o,
  output frame_cmd_t       push_cmd_o
);

  phase_e           phase_q, phase_d;
  logic [7:0]       len_lo_q, len_lo_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [7:0]       crc_q, crc_d;
  logic             accept;
  logic [LEN_W-1:0] fill_inc;
  logic [7:0]       crc_next;

  assign rx_stall_o = ((phase_q == PH_PAYLOAD) && store_busy_i) ||
                      ((phase_q == PH_STOP) && q_full_i);
  assign accept     = rx_valid_i && !rx_stall_o;
  assign fill_inc   = fill_q + LEN_W'(1);
  assign crc_next   = crc8_step(crc_q, rx_byte_i);

  assign wr_en_o    = accept && (phase_q == PH_PAYLOAD);
  assign wr_addr_o  = fill_q[AW-1:0];
  assign wr_data_o  = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_lo_q <= '0;
      len_q    <= '0;
      fill_q   <= '0;
      crc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      len_q    <= len_d;
      fill_q   <= fill_d;
      crc_q    <= crc_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    len_lo_d   = len_lo_q;
    len_d      = len_q;
    fill_d     = fill_q;
    crc_d      = crc_q;
    push_o     = 1'b0;
    push_cmd_o = '{len: len_q, empty: (len_q == '0)};
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) begin
            crc_d   = crc8_step(8'h00, rx_byte_i);
            phase_d = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          len_lo_d = rx_byte_i;
          crc_d    = crc_next;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_d = crc_next;
          len_d = len_lo_q[LEN_W-1:0];
          if ({rx_byte_i, len_lo_q} > 16'(MAX_PAYLOAD)) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_HDR_CRC;
          end
        end
        PH_HDR_CRC: begin
          if (rx_byte_i == crc_q) begin
            crc_d   = crc_next;
            phase_d = PH_DATA_MK;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_DATA_MK: begin
          if (rx_byte_i == DATA_MARK) begin
            crc_d   = crc_next;
            fill_d  = '0;
            phase_d = (len_q == '0) ? PH_PKT_CRC : PH_PAYLOAD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          fill_d = fill_inc;
          crc_d  = crc_next;
          if (fill_inc >= len_q) begin
            phase_d = PH_PKT_CRC;
          end
        end
        PH_PKT_CRC: begin
          phase_d = (rx_byte_i == crc_q) ? PH_STOP : PH_HUNT;
        end
        PH_STOP: begin
          push_o  = (rx_byte_i == STOP_BYTE) && (len_q <= max_accept_len_i);
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

endmodule

// ===== design/crcfr_queue.sv =====
// crcfr_queue: two-entry queue of verified frame requests between the front
// and back parts; uses crcfr_pkg
module crcfr_queue import crcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_cmd_t push_cmd_i,
  input  logic       pop_i,
  output frame_cmd_t head_o,
  output logic       empty_o,
  output logic       full_o
);

  frame_cmd_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign head_o  = entry_q[rptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/crcfr_back.sv =====
// crcfr_back: payload store and drain sequencer that emits the stored bytes
// of each verified frame; uses crcfr_pkg
module crcfr_back import crcfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64,
  parameter int unsigned AW          = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  frame_cmd_t       head_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       data_byte_o,
  output logic [LEN_W-1:0] frame_len_o,
  output logic             is_empty_o,
  output logic             last_o
);

  logic [7:0]       mem_q [MAX_PAYLOAD];
  logic [7:0]       rd_data_q;
  drain_e           state_q, state_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             empty_q, empty_d;
  logic             rd_en;
  logic [LEN_W-1:0] rd_idx;
  logic             is_last;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DR_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      empty_q <= empty_d;
    end
  end

  assign is_last = empty_q || (idx_q == len_q - LEN_W'(1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    empty_d     = empty_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_idx      = '0;
    out_valid_o = 1'b0;
    unique case (state_q)
      DR_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          rd_en   = 1'b1;
          idx_d   = '0;
          len_d   = head_i.len;
          empty_d = head_i.empty;
          state_d = DR_SHOW;
        end
      end
      DR_SHOW: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (is_last) begin
            state_d = DR_IDLE;
          end else begin
            idx_d  = idx_q + LEN_W'(1);
            rd_idx = idx_q + LEN_W'(1);
            rd_en  = 1'b1;
          end
        end
      end
      default: state_d = DR_IDLE;
    endcase
  end

  assign busy_o      = (state_q == DR_SHOW);
  assign data_byte_o = empty_q ? 8'h00 : rd_data_q;
  assign frame_len_o = len_q;
  assign is_empty_o  = empty_q;
  assign last_o      = is_last;

endmodule

// ===== verif/tb_crc8_frame_receiver_unit.sv =====
`timescale 1ns / 100ps
// tb_crc8_frame_receiver_unit: self-checking bench for the crc8 frame receiver,
// with framed and corrupted byte streams, random link gaps and drain stalls
// depends on crcfr_pkg and crc8_frame_receiver_unit
module tb_crc8_frame_receiver_unit;
  import crcfr_pkg::*;

  localparam int PAYLOAD_CAP    = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    FRAME_OK,
    FRAME_BAD_START,
    FRAME_BAD_HDR,
    FRAME_BAD_MARK,
    FRAME_BAD_PKT,
    FRAME_BAD_STOP,
    FRAME_CUT
  } frame_fault_e;

  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             is_empty;
    logic             is_last;
  } frame_byte_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             rx_valid_i = 1'b0;
  logic [7:0]       rx_byte_i = 8'h00;
  logic             rx_stall_o;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [7:0]       data_byte_o;
  logic [LEN_W-1:0] frame_len_o;
  logic             is_empty_o;
  logic             last_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [1:0]       paddr = 2'd0;
  logic [31:0]      pwdata = 32'd0;
  logic [31:0]      prdata;
  logic             pready;

  // deframer state tracked by the bench
  phase_e           link_phase = PH_HUNT;
  logic [15:0]      len_word = 16'd0;
  logic [6:0]       fill_idx = 7'd0;
  logic [7:0]       hdr_sum = 8'h00;
  logic [7:0]       pkt_sum = 8'h00;
  logic [7:0]       payload_mem [0:63];
  logic [LEN_W-1:0] accept_limit = 7'd64;

  frame_byte_t      frame_bytes_due [$];
  logic [7:0]       frame_data [0:63];

  int               err_cnt = 0;
  int               bytes_sent = 0;
  int               framed_bytes = 0;
  int               frames_delivered = 0;
  int               results_checked = 0;
  int               idle_cycles = 0;
  bit               rx_calm = 1'b0;

  crc8_frame_receiver_unit #(
    .MAX_PAYLOAD(PAYLOAD_CAP)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .rx_stall_o  (rx_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .frame_len_o (frame_len_o),
    .is_empty_o  (is_empty_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] m;
    m = 8'($urandom_range(1, 255));
    return x ^ m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_len();
    int r;
    int b;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(0, 6);
    end else if (r < 75) begin
      b = int'(accept_limit) + int'($urandom_range(0, 2)) - 1;
      if (b < 0) b = 0;
      if (b > PAYLOAD_CAP + 1) b = PAYLOAD_CAP + 1;
      return b;
    end else if (r < 78) begin
      return PAYLOAD_CAP;
    end
    return $urandom_range(0, 24);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 200) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  task automatic push_due(input logic [7:0] d, input logic [LEN_W-1:0] n,
                          input logic e, input logic l);
    frame_byte_t fb;
    fb.data     = d;
    fb.len      = n;
    fb.is_empty = e;
    fb.is_last  = l;
    frame_bytes_due.push_back(fb);
  endtask

  // advances the tracked deframer by one link byte and queues what it delivers
  task automatic track_link_byte(input logic [7:0] b);
    int k;
    case (link_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          hdr_sum    = crc8_next(8'h00, b);
          pkt_sum    = hdr_sum;
          link_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_word   = {8'h00, b};
        hdr_sum    = crc8_next(hdr_sum, b);
        pkt_sum    = crc8_next(pkt_sum, b);
        link_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_word[15:8] = b;
        hdr_sum        = crc8_next(hdr_sum, b);
        pkt_sum        = crc8_next(pkt_sum, b);
        link_phase     = (len_word > PAYLOAD_CAP) ? PH_HUNT : PH_HDR_CRC;
      end
      PH_HDR_CRC: begin
        if (b == hdr_sum) begin
          pkt_sum    = crc8_next(pkt_sum, b);
          link_phase = PH_DATA_MK;
        end else begin
          link_phase = PH_HUNT;
        end
      end
      PH_DATA_MK: begin
        if (b == DATA_MARK) begin
          pkt_sum    = crc8_next(pkt_sum, b);
          fill_idx   = 7'd0;
          link_phase = (len_word == 16'd0) ? PH_PKT_CRC : PH_PAYLOAD;
        end else begin
          link_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        payload_mem[fill_idx[5:0]] = b;
        fill_idx = fill_idx + 7'd1;
        pkt_sum  = crc8_next(pkt_sum, b);
        if (fill_idx >= len_word) link_phase = PH_PKT_CRC;
      end
      PH_PKT_CRC: begin
        link_phase = (b == pkt_sum) ? PH_STOP : PH_HUNT;
      end
      default: begin
        if (b == STOP_BYTE && len_word <= accept_limit) begin
          if (len_word == 16'd0) begin
            push_due(8'h00, '0, 1'b1, 1'b1);
          end else begin
            for (k = 0; k < int'(len_word); k++) begin
              push_due(payload_mem[k], len_word[LEN_W-1:0], 1'b0, k == int'(len_word) - 1);
            end
          end
        end
        link_phase = PH_HUNT;
      end
    endcase
  endtask

  // one link byte request; holds it until taken
  task automatic send_link_byte(input logic [7:0] b);
    int gap;
    gap = rx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
    track_link_byte(b);
    bytes_sent++;
  endtask

  task automatic fill_payload();
    int i;
    for (i = 0; i < PAYLOAD_CAP; i++) frame_data[i] = 8'($urandom_range(0, 255));
  endtask

  // builds and sends a frame around frame_data, optionally damaged, or just start and length if oversize
  task automatic send_frame(input logic [15:0] len, input frame_fault_e fault);
    logic [7:0] fb [$];
    logic [7:0] hdr;
    logic [7:0] pkt;
    int         n;
    int         i;
    int         cut;
    n = len;
    fb = {};
    fb.push_back(START_BYTE);
    fb.push_back(len[7:0]);
    fb.push_back(len[15:8]);
    if (n <= PAYLOAD_CAP) begin
      hdr = crc8_next(crc8_next(crc8_next(8'h00, START_BYTE), len[7:0]), len[15:8]);
      fb.push_back(hdr);
      pkt = crc8_next(crc8_next(hdr, hdr), DATA_MARK);
      fb.push_back(DATA_MARK);
      for (i = 0; i < n; i++) begin
        fb.push_back(frame_data[i]);
        pkt = crc8_next(pkt, frame_data[i]);
      end
      fb.push_back(pkt);
      fb.push_back(STOP_BYTE);
      case (fault)
        FRAME_BAD_START: fb[0] = other_than(START_BYTE);
        FRAME_BAD_HDR:   fb[3] = other_than(fb[3]);
        FRAME_BAD_MARK:  fb[4] = other_than(DATA_MARK);
        FRAME_BAD_PKT:   fb[5 + n] = other_than(fb[5 + n]);
        FRAME_BAD_STOP:  fb[6 + n] = other_than(STOP_BYTE);
        FRAME_CUT: begin
          cut = $urandom_range(1, fb.size() - 1);
          while (fb.size() > cut) void'(fb.pop_back());
        end
        default: ;
      endcase
    end
    rx_calm = ($urandom_range(0, 4) == 0);
    for (i = 0; i < fb.size(); i++) send_link_byte(fb[i]);
    framed_bytes += fb.size();
  endtask

  task automatic settle_link();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // brings the link back to hunting, drains, then reprograms the limit and checks the read-back
  task automatic set_accept_limit(input logic [LEN_W-1:0] lim);
    logic [31:0] rd;
    while (link_phase != PH_HUNT) send_link_byte(8'h00);
    settle_link();
    apb_write(ADDR_MAX_ACCEPT, 32'(lim));
    accept_limit = lim;
    @(posedge clk_i);
    apb_read(ADDR_MAX_ACCEPT, rd);
    if (rd[LEN_W-1:0] !== lim) begin
      report_mismatch($sformatf("max_accept_len reads %0d, wrote %0d", rd[LEN_W-1:0], lim));
    end
    @(posedge clk_i);
  endtask

  task automatic test_mixed_traffic(input int budget);
    int           start_count;
    int           r;
    int           n;
    int           len;
    logic [7:0]   nb;
    frame_fault_e fault;
    start_count = framed_bytes;
    while (framed_bytes - start_count < budget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          nb = 8'($urandom_range(0, 255));
          send_link_byte(nb);
        end
      end else if (r < 14) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(PAYLOAD_CAP + 1, 127)
                                          : $urandom_range(PAYLOAD_CAP + 1, 65535);
        send_frame(len[15:0], FRAME_OK);
      end else begin
        fill_payload();
        len = pick_len();
        fault = (r < 80) ? FRAME_OK
                         : frame_fault_e'($urandom_range(FRAME_BAD_START, FRAME_CUT));
        send_frame(len[15:0], fault);
      end
    end
  endtask

  // empty frame, one-byte frame, oversize lengths, a start byte in place of a wrong header crc
  task automatic test_corner_frames();
    logic [7:0] hc;
    send_frame(16'd0, FRAME_OK);
    frame_data[0] = 8'hFF;
    send_frame(16'd1, FRAME_OK);
    send_frame(16'h0041, FRAME_OK);
    send_frame(16'h8000, FRAME_OK);
    hc = crc8_next(crc8_next(crc8_next(8'h00, START_BYTE), 8'h00), 8'h00);
    send_link_byte(START_BYTE);
    send_link_byte(8'h00);
    send_link_byte(8'h00);
    send_link_byte((hc == START_BYTE) ? other_than(hc) : START_BYTE);
  endtask

  task automatic test_limit_default();
    set_accept_limit(7'd64);
    test_mixed_traffic(60);
  endtask

  task automatic test_limit_zero();
    set_accept_limit(7'd0);
    test_mixed_traffic(25);
  endtask

  task automatic test_limit_open();
    set_accept_limit(7'd127);
    fill_payload();
    send_frame(16'(PAYLOAD_CAP), FRAME_OK);
    test_mixed_traffic(20);
  endtask

  task automatic test_limit_random();
    logic [LEN_W-1:0] lim;
    lim = LEN_W'($urandom_range(1, PAYLOAD_CAP - 1));
    set_accept_limit(lim);
    test_mixed_traffic(40);
  endtask

  // drain side backpressure: quiet stretches, sparse stalls, long holds
  initial begin
    int mode;
    int span;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 99);
      span = $urandom_range(5, 40);
      repeat (span) begin
        @(posedge clk_i);
        if (mode < 30) begin
          out_stall_i <= 1'b0;
        end else if (mode < 85) begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end else begin
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%02h len=%0d empty=%0b last=%0b",
                                  data_byte_o, frame_len_o, is_empty_o, last_o));
      end else begin
        want = frame_bytes_due.pop_front();
        results_checked++;
        if (want.is_last) frames_delivered++;
        if (is_empty_o !== want.is_empty || last_o !== want.is_last ||
            frame_len_o !== want.len || (!want.is_empty && data_byte_o !== want.data)) begin
          report_mismatch($sformatf(
            "got data=%02h len=%0d empty=%0b last=%0b, want data=%02h len=%0d empty=%0b last=%0b",
            data_byte_o, frame_len_o, is_empty_o, last_o,
            want.data, want.len, want.is_empty, want.is_last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && !rx_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, frame_bytes_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_frames();
    test_limit_default();
    test_limit_zero();
    test_limit_open();
    test_limit_random();
    settle_link();
    $display("run covered %0d link bytes, %0d frames delivered, %0d results checked",
             bytes_sent, frames_delivered, results_checked);
    $display("limits 64, 0, 127 and %0d with damaged frames, oversize lengths and noise",
             accept_limit);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
